@@ hw/rtl/y2r_pkg.sv @@
// shared types, constants and arithmetic helpers for the yuv 4:1:1 unpacker
`timescale 1ns / 1ps

package y2r_pkg;

    localparam int QUEUE_DEPTH = 2;

    // fixed-point chroma weights, scaled by 2048
    localparam logic [11:0] K_R_V = 12'd1434;
    localparam logic [11:0] K_G_U = 12'd406;
    localparam logic [11:0] K_G_V = 12'd595;
    localparam logic [11:0] K_B_U = 12'd2078;

    localparam logic [8:0] CHROMA_OFFSET = 9'd128;

    // one word's worth of pixels, all sharing one chroma pair
    typedef struct packed {
        logic            gray;
        logic [1:0]      last_idx;
        logic [3:0][7:0] luma;
        logic [7:0]      u;
        logic [7:0]      v;
    } job_t;

    // floor((c - 128) * k / 2048), fits -130..128
    function automatic logic signed [9:0] chroma_term(input logic [7:0] c,
                                                      input logic [11:0] k);
        logic signed [8:0]  cs;
        logic signed [21:0] p;
        cs = $signed({1'b0, c}) - $signed(CHROMA_OFFSET);
        p  = 22'(cs * $signed({1'b0, k}));
        return p[20:11];
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [10:0] x);
        logic [7:0] r;
        if (x < 0)
        begin
            r = 8'd0;
        end
        else if (x > 11'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = x[7:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/y2r_front.sv @@
// word intake: tracks group phase and held bytes, builds one pixel job per word
`timescale 1ns / 1ps

module y2r_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          gray_only,
    input  logic          in_valid,
    input  logic [31:0]   packed_word,
    input  logic          frame_start,
    input  logic          job_ready,
    output logic          in_ready,
    output logic          job_valid,
    output y2r_pkg::job_t job
);

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_u_reg, held_u_next;
    logic [7:0] held_v_reg, held_v_next;
    logic [7:0] pend_luma_reg, pend_luma_next;
    logic [7:0] pend_u_reg, pend_u_next;

    logic [1:0] phase_cur;
    logic [7:0] b0, b1, b2, b3;
    logic       xfer;

    assign b0 = packed_word[7:0];
    assign b1 = packed_word[15:8];
    assign b2 = packed_word[23:16];
    assign b3 = packed_word[31:24];

    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign xfer      = in_valid && job_ready;
    assign phase_cur = frame_start ? PH_FIRST : phase_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        held_u_next    = held_u_reg;
        held_v_next    = held_v_reg;
        pend_luma_next = pend_luma_reg;
        pend_u_next    = pend_u_reg;
        job.gray       = gray_only;
        job.last_idx   = 2'd1;
        job.luma       = '0;
        job.u          = b0;
        job.v          = b3;
        case (phase_cur)
            PH_SECOND:
            begin
                job.u = held_u_reg;
                job.v = held_v_reg;
                if (gray_only)
                begin
                    job.last_idx = 2'd2;
                    job.luma     = {8'd0, b3, b1, b0};
                end
                else
                begin
                    job.luma = {16'd0, b1, b0};
                end
                pend_u_next    = b2;
                pend_luma_next = b3;
                phase_next     = PH_THIRD;
            end
            PH_THIRD:
            begin
                job.u = pend_u_reg;
                job.v = b1;
                if (gray_only)
                begin
                    job.last_idx = 2'd2;
                    job.luma     = {8'd0, b3, b2, b0};
                end
                else
                begin
                    job.last_idx = 2'd3;
                    job.luma     = {b3, b2, b0, pend_luma_reg};
                end
                held_u_next = pend_u_reg;
                held_v_next = b1;
                phase_next  = PH_FIRST;
            end
            default:
            begin
                // first word of a group, also the unused phase code
                job.luma    = {16'd0, b2, b1};
                held_u_next = b0;
                held_v_next = b3;
                phase_next  = PH_SECOND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            held_u_reg    <= '0;
            held_v_reg    <= '0;
            pend_luma_reg <= '0;
            pend_u_reg    <= '0;
        end
        else if (xfer)
        begin
            phase_reg     <= phase_next;
            held_u_reg    <= held_u_next;
            held_v_reg    <= held_v_next;
            pend_luma_reg <= pend_luma_next;
            pend_u_reg    <= pend_u_next;
        end
    end

endmodule

@@ hw/rtl/y2r_queue.sv @@
// short job queue between intake and pixel pipeline
`timescale 1ns / 1ps

module y2r_queue
#(
    parameter int DEPTH = y2r_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  y2r_pkg::job_t push_data,
    input  logic          pop,
    output logic          not_full,
    output logic          not_empty,
    output y2r_pkg::job_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    y2r_pkg::job_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> not_full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("job queue read while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("job queue count lost a push");

endmodule

@@ hw/rtl/y2r_back.sv @@
// pixel pipeline: one job pixel per unstalled cycle; converts, clamps
`timescale 1ns / 1ps

module y2r_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_avail,
    input  y2r_pkg::job_t head,
    output logic          job_pop,
    output logic          out_valid,
    output logic [31:0]   pixel,
    output logic          last,
    input  logic          out_ready
);

    logic [1:0] idx_reg, idx_next;
    logic       en;
    logic       issue;

    // stage b: selected pixel
    logic       b_valid_reg;
    logic [7:0] b_y_reg, b_u_reg, b_v_reg;
    logic       b_gray_reg, b_last_reg;

    // stage c: chroma terms
    logic              c_valid_reg;
    logic [7:0]        c_y_reg;
    logic signed [9:0] c_rt_reg, c_bt_reg;
    logic signed [10:0] c_gt_reg;
    logic              c_gray_reg, c_last_reg;

    // stage d: output register
    logic        d_valid_reg;
    logic [31:0] d_pixel_reg;
    logic        d_last_reg;

    logic signed [9:0]  gu_term, gv_term;
    logic signed [10:0] y_s, r_sum, g_sum, b_sum;
    logic [31:0]        pixel_next;

    // whole pipeline holds while the output waits
    assign en      = !d_valid_reg || out_ready;
    assign issue   = en && job_avail;
    assign job_pop = issue && (idx_reg == head.last_idx);

    assign idx_next = job_pop ? 2'd0 : idx_reg + 2'd1;

    assign gu_term = y2r_pkg::chroma_term(b_u_reg, y2r_pkg::K_G_U);
    assign gv_term = y2r_pkg::chroma_term(b_v_reg, y2r_pkg::K_G_V);

    assign y_s   = $signed({3'b000, c_y_reg});
    assign r_sum = y_s + {c_rt_reg[9], c_rt_reg};
    assign g_sum = y_s - c_gt_reg;
    assign b_sum = y_s + {c_bt_reg[9], c_bt_reg};

    always_comb
    begin
        if (c_gray_reg)
        begin
            pixel_next = {4{c_y_reg}};
        end
        else
        begin
            pixel_next = {c_y_reg, y2r_pkg::clamp8(b_sum),
                          y2r_pkg::clamp8(g_sum), y2r_pkg::clamp8(r_sum)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (issue)
            begin
                idx_reg <= idx_next;
            end
            b_valid_reg <= issue;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_y_reg     <= head.luma[idx_reg];
            b_u_reg     <= head.u;
            b_v_reg     <= head.v;
            b_gray_reg  <= head.gray;
            b_last_reg  <= (idx_reg == head.last_idx);

            c_y_reg     <= b_y_reg;
            c_rt_reg    <= y2r_pkg::chroma_term(b_v_reg, y2r_pkg::K_R_V);
            c_bt_reg    <= y2r_pkg::chroma_term(b_u_reg, y2r_pkg::K_B_U);
            c_gt_reg    <= {gu_term[9], gu_term} + {gv_term[9], gv_term};
            c_gray_reg  <= b_gray_reg;
            c_last_reg  <= b_last_reg;

            d_pixel_reg <= pixel_next;
            d_last_reg  <= c_last_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign pixel     = d_pixel_reg;
    assign last      = d_last_reg;

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_avail |-> idx_reg <= head.last_idx)
        else $error("pixel index past end of job");

    a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !job_avail |-> idx_reg == 2'd0)
        else $error("pixel index not rewound between jobs");

    a_pop_resets_idx: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> idx_reg == 2'd0)
        else $error("pixel index not cleared after job done");

endmodule

@@ hw/rtl/yuv411_to_rgb_unpacker_unit.sv @@
// top level: yuv 4:1:1 word stream in, rgb or gray pixel stream out
`timescale 1ns / 1ps
// a transferred word is written to the job queue, then each pixel passes stages b, c, d
// throughput: one pixel per cycle while the output is ready; a word yields
// 2, 2, 4 pixels in colour and 2, 3, 3 in gray over the three words of a group
// the pixel pipeline is the limit; the job queue lets intake run ahead
// reset: phase and held bytes cleared, queue and pipeline emptied, colour mode

module yuv411_to_rgb_unpacker_unit
#(
    parameter int QUEUE_DEPTH = y2r_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,      // gray_only
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // packed_word
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // pixel
    output logic        m_axis_tlast
);

    logic          gray_only_reg;
    logic          q_not_full, q_not_empty, q_push, q_pop;
    y2r_pkg::job_t front_job, head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_only_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            gray_only_reg <= cfg_wdata;
        end
    end

    y2r_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .gray_only   (gray_only_reg),
        .in_valid    (s_axis_tvalid),
        .packed_word (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .job_ready   (q_not_full),
        .in_ready    (s_axis_tready),
        .job_valid   (q_push),
        .job         (front_job)
    );

    y2r_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push && q_not_full),
        .push_data (front_job),
        .pop       (q_pop),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .head      (head_job)
    );

    y2r_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (q_not_empty),
        .head      (head_job),
        .job_pop   (q_pop),
        .out_valid (m_axis_tvalid),
        .pixel     (m_axis_tdata),
        .last      (m_axis_tlast),
        .out_ready (m_axis_tready)
    );

endmodule

@@ sim/yuv411_pixel_checker.sv @@
// pixel checker for the yuv 4:1:1 unpacker: predicts pixels per word transfer and compares
`timescale 1ns / 1ps

module yuv411_pixel_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // packed_word
    input  logic        s_axis_tuser,   // frame_start
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // pixel
    input  logic        m_axis_tlast,
    output int          pixels_pending,
    output int          mismatch_count
);

    localparam int W_R_V = 1434;
    localparam int W_G_U = 406;
    localparam int W_G_V = 595;
    localparam int W_B_U = 2078;
    localparam int UV_BIAS = 128;

    typedef enum logic [1:0] {GROUP_WORD0, GROUP_WORD1, GROUP_WORD2} group_word_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic        end_of_word;
    } pixel_exp_t;

    pixel_exp_t  expected_pixels [$];
    logic        gray_mode;
    group_word_t word_phase;
    logic [7:0]  held_u;
    logic [7:0]  held_v;
    logic [7:0]  carry_luma;
    logic [7:0]  carry_u;

    // floor of (c - 128) * k / 2048
    function automatic int chroma_part(input logic [7:0] c, input int k);
        return ((int'(c) - UV_BIAS) * k) >>> 11;
    endfunction

    function automatic logic [7:0] sat_byte(input int x);
        logic [7:0] r;
        if (x < 0)
        begin
            r = 8'd0;
        end
        else if (x > 255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = x[7:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] colour_pixel(input logic [7:0] y, input logic [7:0] u,
                                                 input logic [7:0] v);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = sat_byte(int'(y) + chroma_part(v, W_R_V));
        g = sat_byte(int'(y) - chroma_part(u, W_G_U) - chroma_part(v, W_G_V));
        b = sat_byte(int'(y) + chroma_part(u, W_B_U));
        return {y, b, g, r};
    endfunction

    task automatic predict_word(input logic [31:0] w, input logic fs);
        logic [7:0]  octet [4];
        logic [31:0] px [4];
        int          n;
        pixel_exp_t  entry;
        octet[0] = w[7:0];
        octet[1] = w[15:8];
        octet[2] = w[23:16];
        octet[3] = w[31:24];
        n = 0;
        if (fs)
        begin
            word_phase = GROUP_WORD0;
        end
        case (word_phase)
            GROUP_WORD1:
            begin
                if (gray_mode)
                begin
                    px[0] = {4{octet[0]}};
                    px[1] = {4{octet[1]}};
                    px[2] = {4{octet[3]}};
                    n = 3;
                end
                else
                begin
                    px[0] = colour_pixel(octet[0], held_u, held_v);
                    px[1] = colour_pixel(octet[1], held_u, held_v);
                    n = 2;
                end
                carry_u = octet[2];
                carry_luma = octet[3];
                word_phase = GROUP_WORD2;
            end
            GROUP_WORD2:
            begin
                if (gray_mode)
                begin
                    px[0] = {4{octet[0]}};
                    px[1] = {4{octet[2]}};
                    px[2] = {4{octet[3]}};
                    n = 3;
                end
                else
                begin
                    // luma carried over from the middle word goes first
                    px[0] = colour_pixel(carry_luma, carry_u, octet[1]);
                    px[1] = colour_pixel(octet[0], carry_u, octet[1]);
                    px[2] = colour_pixel(octet[2], carry_u, octet[1]);
                    px[3] = colour_pixel(octet[3], carry_u, octet[1]);
                    n = 4;
                end
                held_u = carry_u;
                held_v = octet[1];
                word_phase = GROUP_WORD0;
            end
            default:
            begin
                if (gray_mode)
                begin
                    px[0] = {4{octet[1]}};
                    px[1] = {4{octet[2]}};
                end
                else
                begin
                    px[0] = colour_pixel(octet[1], octet[0], octet[3]);
                    px[1] = colour_pixel(octet[2], octet[0], octet[3]);
                end
                n = 2;
                held_u = octet[0];
                held_v = octet[3];
                word_phase = GROUP_WORD1;
            end
        endcase
        for (int i = 0; i < n; i++)
        begin
            entry.pixel = px[i];
            entry.end_of_word = (i == n - 1);
            expected_pixels.push_back(entry);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            gray_mode = 1'b0;
            word_phase = GROUP_WORD0;
            held_u = 8'd0;
            held_v = 8'd0;
            carry_luma = 8'd0;
            carry_u = 8'd0;
            mismatch_count = 0;
            pixels_pending <= 0;
        end
        else
        begin
            // compare before predicting so a pixel never meets its own word
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch("unexpected pixel", 32'd0, m_axis_tdata);
                end
                else
                begin
                    if (m_axis_tdata !== expected_pixels[0].pixel)
                    begin
                        report_mismatch("pixel", expected_pixels[0].pixel, m_axis_tdata);
                    end
                    if (m_axis_tlast !== expected_pixels[0].end_of_word)
                    begin
                        report_mismatch("tlast", {31'd0, expected_pixels[0].end_of_word},
                                        {31'd0, m_axis_tlast});
                    end
                    void'(expected_pixels.pop_front());
                end
            end
            if (cfg_we)
            begin
                gray_mode = cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_word(s_axis_tdata, s_axis_tuser);
            end
            pixels_pending <= expected_pixels.size();
        end
    end

endmodule

@@ sim/yuv411_to_rgb_unpacker_unit_test.sv @@
// testbench top for the yuv 4:1:1 unpacker: clock, reset, word stimulus and verdict
`timescale 1ns / 1ps

module yuv411_to_rgb_unpacker_unit_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 200;
    localparam logic MODE_COLOUR = 1'b0;
    localparam logic MODE_GRAY = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    int pixels_pending;
    int mismatch_count;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    always #5 clk = ~clk;

    yuv411_to_rgb_unpacker_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    yuv411_pixel_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .pixels_pending (pixels_pending),
        .mismatch_count (mismatch_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // pixel receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // called at a rising edge, returns at the edge of the transfer
    task automatic push_word(input logic [31:0] w, input logic fs);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        s_axis_tuser <= fs;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pixels_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic gray);
        cfg_we <= 1'b1;
        cfg_wdata <= gray;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0: v = 8'h00;
            1: v = 8'hff;
            2: v = 8'h80;
            3: v = 8'h7f;
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    // mostly whole groups inside frames, with stray frame starts and ragged frames
    task automatic stream_frames(input int n_words);
        int          words_left;
        logic        fs;
        logic [31:0] w;
        words_left = 0;
        for (int i = 0; i < n_words; i++)
        begin
            if (words_left <= 0)
            begin
                fs = 1'b1;
                words_left = 3 * $urandom_range(1, 4);
                if ($urandom_range(0, 9) == 0)
                begin
                    words_left += $urandom_range(1, 2);
                end
            end
            else
            begin
                fs = ($urandom_range(0, 39) == 0);
            end
            w = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
            push_word(w, fs);
            words_left--;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(MODE_COLOUR);
        // extremes of luma and chroma, frame start in the first and third word positions
        push_word(32'h00000000, 1'b1);
        push_word(32'hffffffff, 1'b0);
        push_word(32'h80808080, 1'b0);
        push_word(32'hff0000ff, 1'b1);
        push_word(32'h00ffff00, 1'b0);
        push_word(32'hff00ff00, 1'b0);
        push_word(32'h00ffffff, 1'b1);
        push_word(32'h12345678, 1'b0);
        push_word(32'ha5c37e81, 1'b1);
        push_word(32'h01020304, 1'b0);
        push_word(32'h807f8180, 1'b1);
        push_word(32'hdeadbeef, 1'b0);
        settle();
        // mode changes in the middle of a group
        write_mode(MODE_GRAY);
        push_word(32'hcafef00d, 1'b0);
        push_word(32'h00ff00ff, 1'b0);
        push_word(32'hff00ff00, 1'b0);
        settle();
        write_mode(MODE_COLOUR);
        push_word(32'h55aa55aa, 1'b0);
        push_word(32'hffffffff, 1'b1);
        settle();
        write_mode(MODE_GRAY);
        push_word(32'h0f0f0f0f, 1'b0);
        push_word(32'hf0f0f0f0, 1'b0);
        push_word(32'h80808080, 1'b1);
        settle();

        write_mode(MODE_COLOUR);
        stream_frames(40);
        settle();

        write_mode(MODE_GRAY);
        idle_pct = 56;
        stream_frames(40);
        settle();

        // long output hold-off while words keep coming, so intake backs up
        write_mode(MODE_COLOUR);
        idle_pct = 0;
        stall_pct = 56;
        stream_frames(12);
        hold_requests <= hold_requests + 1;
        stream_frames(28);
        settle();

        write_mode(MODE_GRAY);
        idle_pct = 32;
        stall_pct = 32;
        stream_frames(20);
        // sender pause until every pixel is out
        settle();
        write_mode(MODE_COLOUR);
        stream_frames(20);
        settle();

        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
